[rtl/tsl_pkg.sv]
package tsl_pkg;

  // Table geometry
  localparam int STATE_COUNT  = 64;
  localparam int ACTION_COUNT = 8;
  localparam int TABLE_DEPTH  = STATE_COUNT * ACTION_COUNT;
  localparam int IDX_W        = $clog2(TABLE_DEPTH);
  localparam int CNT_W        = $clog2(TABLE_DEPTH + 2);
  localparam int STATE_W      = 6;
  localparam int ACTION_W     = 3;
  localparam int VALUE_W      = 32;
  localparam int TRACE_W      = 24;
  localparam int COEF_W       = 17;

  localparam logic [COEF_W-1:0]  ONE_Q16   = 17'd65536;
  localparam logic [TRACE_W-1:0] TRACE_MAX = 24'hFFFFFF;

  // Operation codes
  localparam logic [1:0] OP_START = 2'd0;
  localparam logic [1:0] OP_STEP  = 2'd1;
  localparam logic [1:0] OP_END   = 2'd2;

  // Configuration register indexes
  localparam logic [1:0] REG_DISCOUNT    = 2'd0;
  localparam logic [1:0] REG_TRACE_DECAY = 2'd1;
  localparam logic [1:0] REG_LEARN_RATE  = 2'd2;
  localparam logic [1:0] REG_ACCUMULATE  = 2'd3;

  // Commands from controller to datapath
  typedef struct packed {
    logic             load;       // capture input transaction
    logic             rd_cur;     // read held pair entry
    logic             rd_nxt;     // read next pair entry
    logic             cap_cur;    // capture held pair data
    logic             cap_nxt;    // form bootstrap product
    logic             calc_delta; // form td error
    logic             calc_gain;  // form gain product, write bumped trace
    logic             round_gain; // register rounded gain
    logic             sweep_rd;   // issue sweep read at idx
    logic             zero_trace; // write zero trace at idx
    logic             clear_all;  // write zero to both tables at idx
    logic             finish;     // update held pair and result
    logic [IDX_W-1:0] idx;
  } cmd_t;

  // Saturate a wide signed value to 32 bits
  function automatic logic [VALUE_W-1:0] sat32(input logic signed [43:0] v);
    logic [VALUE_W-1:0] r;
    if (v > 44'sh0007FFFFFFF) r = 32'h7FFFFFFF;
    else if (v < -44'sh00080000000) r = 32'h80000000;
    else r = v[VALUE_W-1:0];
    return r;
  endfunction

  // Limit a Q1.16 coefficient to one
  function automatic logic [COEF_W-1:0] clamp_one(input logic [COEF_W-1:0] r);
    return (r > ONE_Q16) ? ONE_Q16 : r;
  endfunction

endpackage

[rtl/tsl_ram.sv]
module tsl_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 512
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  // Write port and registered read port
  always_ff @(posedge clk_i) begin
    if (we_i) mem_q[waddr_i] <= wdata_i;
    rdata_o <= mem_q[raddr_i];
  end

endmodule

[rtl/tsl_ctrl.sv]
module tsl_ctrl (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           in_valid_i,
  output logic           in_ready_o,
  input  logic [1:0]     in_op_i,
  output logic           out_valid_o,
  input  logic           out_ready_i,
  output tsl_pkg::cmd_t  cmd_o
);

  typedef enum logic [10:0] {
    ST_CLEAR  = 11'b00000000001,
    ST_IDLE   = 11'b00000000010,
    ST_RDCUR  = 11'b00000000100,
    ST_RDNXT  = 11'b00000001000,
    ST_MUL    = 11'b00000010000,
    ST_DELTA  = 11'b00000100000,
    ST_GAIN   = 11'b00001000000,
    ST_GAIN2  = 11'b00010000000,
    ST_SWEEP  = 11'b00100000000,
    ST_ZERO   = 11'b01000000000,
    ST_FINISH = 11'b10000000000
  } state_e;

  state_e                     state_q, state_d;
  logic [tsl_pkg::CNT_W-1:0]  cnt_q, cnt_d;
  logic                       out_valid_q, out_valid_d;
  logic                       accept;

  assign in_ready_o  = (state_q == ST_IDLE);
  assign accept      = in_valid_i & in_ready_o;
  assign out_valid_o = out_valid_q;

  // Sequence one transaction
  always_comb begin
    state_d     = state_q;
    cnt_d       = cnt_q;
    out_valid_d = out_valid_q & ~out_ready_i;
    cmd_o       = '0;
    cmd_o.idx   = cnt_q[tsl_pkg::IDX_W-1:0];
    unique case (state_q)
      ST_CLEAR: begin
        cmd_o.clear_all = 1'b1;
        cnt_d = cnt_q + 1'b1;
        if (cnt_q == tsl_pkg::CNT_W'(tsl_pkg::TABLE_DEPTH - 1)) state_d = ST_IDLE;
      end
      ST_IDLE: begin
        cnt_d = '0;
        if (accept) begin
          cmd_o.load = 1'b1;
          priority if (in_op_i == tsl_pkg::OP_START) state_d = ST_ZERO;
          else if (in_op_i == tsl_pkg::OP_STEP || in_op_i == tsl_pkg::OP_END)
            state_d = ST_RDCUR;
          else state_d = ST_FINISH;
        end
      end
      ST_RDCUR: begin
        cmd_o.rd_cur = 1'b1;
        state_d = ST_RDNXT;
      end
      ST_RDNXT: begin
        cmd_o.rd_nxt  = 1'b1;
        cmd_o.cap_cur = 1'b1;
        state_d = ST_MUL;
      end
      ST_MUL: begin
        cmd_o.cap_nxt = 1'b1;
        state_d = ST_DELTA;
      end
      ST_DELTA: begin
        cmd_o.calc_delta = 1'b1;
        state_d = ST_GAIN;
      end
      ST_GAIN: begin
        cmd_o.calc_gain = 1'b1;
        state_d = ST_GAIN2;
      end
      ST_GAIN2: begin
        cmd_o.round_gain = 1'b1;
        cnt_d = '0;
        state_d = ST_SWEEP;
      end
      ST_SWEEP: begin
        cmd_o.sweep_rd = (cnt_q < tsl_pkg::CNT_W'(tsl_pkg::TABLE_DEPTH));
        cnt_d = cnt_q + 1'b1;
        if (cnt_q == tsl_pkg::CNT_W'(tsl_pkg::TABLE_DEPTH + 1)) state_d = ST_FINISH;
      end
      ST_ZERO: begin
        cmd_o.zero_trace = 1'b1;
        cnt_d = cnt_q + 1'b1;
        if (cnt_q == tsl_pkg::CNT_W'(tsl_pkg::TABLE_DEPTH - 1)) state_d = ST_FINISH;
      end
      ST_FINISH: begin
        if (!out_valid_q || out_ready_i) begin
          cmd_o.finish = 1'b1;
          out_valid_d  = 1'b1;
          state_d      = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_CLEAR;
      cnt_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      cnt_q       <= cnt_d;
      out_valid_q <= out_valid_d;
    end
  end

endmodule

[rtl/tsl_datapath.sv]
module tsl_datapath (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  tsl_pkg::cmd_t                     cmd_i,
  input  logic [1:0]                        in_op_i,
  input  logic signed [31:0]                in_reward_i,
  input  logic [tsl_pkg::STATE_W-1:0]       in_next_state_i,
  input  logic [tsl_pkg::ACTION_W-1:0]      in_next_action_i,
  input  logic                              cfg_we_i,
  input  logic [1:0]                        cfg_index_i,
  input  logic [16:0]                       cfg_data_i,
  output logic signed [31:0]                out_td_error_o,
  output logic [tsl_pkg::STATE_W-1:0]       out_current_state_o,
  output logic [tsl_pkg::ACTION_W-1:0]      out_current_action_o
);

  localparam int IW = tsl_pkg::IDX_W;

  // Configuration registers
  logic [16:0] discount_q, trace_decay_q, learn_rate_q;
  logic        accumulate_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      discount_q    <= 17'd62259;
      trace_decay_q <= 17'd65536;
      learn_rate_q  <= 17'd6554;
      accumulate_q  <= 1'b1;
    end else if (cfg_we_i) begin
      unique case (cfg_index_i)
        tsl_pkg::REG_DISCOUNT:    discount_q    <= cfg_data_i;
        tsl_pkg::REG_TRACE_DECAY: trace_decay_q <= cfg_data_i;
        tsl_pkg::REG_LEARN_RATE:  learn_rate_q  <= cfg_data_i;
        tsl_pkg::REG_ACCUMULATE:  accumulate_q  <= cfg_data_i[0];
        default: ;
      endcase
    end
  end

  logic [16:0] gamma, lambda, alpha;
  assign gamma  = tsl_pkg::clamp_one(discount_q);
  assign lambda = tsl_pkg::clamp_one(trace_decay_q);
  assign alpha  = tsl_pkg::clamp_one(learn_rate_q);

  // Captured transaction
  logic [1:0]                   op_q;
  logic signed [31:0]           reward_q;
  logic [tsl_pkg::STATE_W-1:0]  ns_q;
  logic [tsl_pkg::ACTION_W-1:0] na_q;

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      op_q     <= in_op_i;
      reward_q <= in_reward_i;
      ns_q     <= tsl_pkg::STATE_W'(in_next_state_i % tsl_pkg::STATE_COUNT);
      na_q     <= tsl_pkg::ACTION_W'(in_next_action_i % tsl_pkg::ACTION_COUNT);
    end
  end

  // Held pair
  logic [tsl_pkg::STATE_W-1:0]  held_s_q;
  logic [tsl_pkg::ACTION_W-1:0] held_a_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      held_s_q <= '0;
      held_a_q <= '0;
    end else if (cmd_i.finish && (op_q == tsl_pkg::OP_START || op_q == tsl_pkg::OP_STEP)) begin
      held_s_q <= ns_q;
      held_a_q <= na_q;
    end
  end

  logic [IW-1:0] cur_idx, nxt_idx;
  assign cur_idx = IW'(held_s_q) * IW'(tsl_pkg::ACTION_COUNT) + IW'(held_a_q);
  assign nxt_idx = IW'(ns_q) * IW'(tsl_pkg::ACTION_COUNT) + IW'(na_q);

  // Table memories
  logic                        v_we, t_we;
  logic [IW-1:0]               v_waddr, t_waddr, raddr;
  logic [31:0]                 v_wdata, v_rdata;
  logic [tsl_pkg::TRACE_W-1:0] t_wdata, t_rdata;

  tsl_ram #(.WIDTH(32), .DEPTH(tsl_pkg::TABLE_DEPTH)) u_value_ram (
    .clk_i   (clk_i),
    .we_i    (v_we),
    .waddr_i (v_waddr),
    .wdata_i (v_wdata),
    .raddr_i (raddr),
    .rdata_o (v_rdata)
  );

  tsl_ram #(.WIDTH(tsl_pkg::TRACE_W), .DEPTH(tsl_pkg::TABLE_DEPTH)) u_trace_ram (
    .clk_i   (clk_i),
    .we_i    (t_we),
    .waddr_i (t_waddr),
    .wdata_i (t_wdata),
    .raddr_i (raddr),
    .rdata_o (t_rdata)
  );

  // Select read address
  always_comb begin
    priority if (cmd_i.rd_cur) raddr = cur_idx;
    else if (cmd_i.rd_nxt) raddr = nxt_idx;
    else raddr = cmd_i.idx;
  end

  // Scalar stages for the td error and gain
  logic signed [31:0]           qcur_q;
  logic [tsl_pkg::TRACE_W-1:0]  tcur_q;
  logic signed [49:0]           boot_prod_q, gain_prod_q;
  logic [33:0]                  g_prod_q;
  logic [16:0]                  g_q;
  logic signed [31:0]           delta_q;
  logic signed [33:0]           gain_q;
  logic signed [49:0]           boot_rnd, gain_rnd;
  logic signed [35:0]           raw;
  logic [33:0]                  g_rnd;
  logic [24:0]                  bump_sum;
  logic [tsl_pkg::TRACE_W-1:0]  bumped;

  assign boot_rnd = boot_prod_q + 50'sd32768;
  assign gain_rnd = gain_prod_q + 50'sd32768;
  assign g_rnd    = g_prod_q + 34'd32768;
  assign raw = 36'(reward_q) - 36'(qcur_q)
             + ((op_q == tsl_pkg::OP_STEP) ? 36'($signed(boot_rnd[49:16])) : 36'sd0);
  assign bump_sum = {1'b0, tcur_q} + 25'h10000;
  assign bumped = !accumulate_q ? tsl_pkg::TRACE_W'(tsl_pkg::ONE_Q16)
                : (bump_sum > {1'b0, tsl_pkg::TRACE_MAX}) ? tsl_pkg::TRACE_MAX
                : bump_sum[tsl_pkg::TRACE_W-1:0];

  always_ff @(posedge clk_i) begin
    if (cmd_i.cap_cur) begin
      qcur_q <= v_rdata;
      tcur_q <= t_rdata;
    end
    if (cmd_i.cap_nxt) begin
      boot_prod_q <= $signed({1'b0, gamma}) * $signed(v_rdata);
      g_prod_q    <= gamma * lambda;
    end
    if (cmd_i.calc_delta) begin
      delta_q <= tsl_pkg::sat32(44'(raw));
      g_q     <= g_rnd[32:16];
    end
    if (cmd_i.calc_gain) gain_prod_q <= $signed({1'b0, alpha}) * delta_q;
    if (cmd_i.round_gain) gain_q <= gain_rnd[49:16];
  end

  // Sweep pipeline: read, multiply, update and write back
  logic                        s1_v_q, s2_v_q;
  logic [IW-1:0]               s1_idx_q, s2_idx_q;
  logic signed [31:0]          s2_val_q;
  logic [tsl_pkg::TRACE_W-1:0] s2_tr_q;
  logic signed [58:0]          inc_prod_q, inc_rnd;
  logic [40:0]                 dec_prod_q, dec_rnd;
  logic signed [43:0]          new_val;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_v_q <= 1'b0;
      s2_v_q <= 1'b0;
    end else begin
      s1_v_q <= cmd_i.sweep_rd;
      s2_v_q <= s1_v_q;
    end
  end

  always_ff @(posedge clk_i) begin
    s1_idx_q   <= cmd_i.idx;
    s2_idx_q   <= s1_idx_q;
    s2_val_q   <= v_rdata;
    s2_tr_q    <= t_rdata;
    inc_prod_q <= gain_q * $signed({1'b0, t_rdata});
    dec_prod_q <= g_q * t_rdata;
  end

  assign inc_rnd = inc_prod_q + 59'sd32768;
  assign dec_rnd = dec_prod_q + 41'd32768;
  assign new_val = 44'(s2_val_q) + 44'($signed(inc_rnd[58:16]));

  // Table write ports
  always_comb begin
    v_we    = 1'b0;
    v_waddr = cmd_i.idx;
    v_wdata = '0;
    t_we    = 1'b0;
    t_waddr = cmd_i.idx;
    t_wdata = '0;
    priority if (cmd_i.clear_all) begin
      v_we = 1'b1;
      t_we = 1'b1;
    end else if (cmd_i.zero_trace) begin
      t_we = 1'b1;
    end else if (cmd_i.calc_gain) begin
      t_we    = 1'b1;
      t_waddr = cur_idx;
      t_wdata = bumped;
    end else if (s2_v_q) begin
      v_we    = 1'b1;
      v_waddr = s2_idx_q;
      v_wdata = tsl_pkg::sat32(new_val);
      t_we    = 1'b1;
      t_waddr = s2_idx_q;
      t_wdata = (op_q == tsl_pkg::OP_STEP) ? dec_rnd[39:16] : s2_tr_q;
    end
  end

  // Result register
  always_ff @(posedge clk_i) begin
    if (cmd_i.finish) begin
      out_td_error_o <= (op_q == tsl_pkg::OP_STEP || op_q == tsl_pkg::OP_END)
                        ? delta_q : 32'sd0;
      out_current_state_o  <= (op_q == tsl_pkg::OP_START || op_q == tsl_pkg::OP_STEP)
                              ? ns_q : held_s_q;
      out_current_action_o <= (op_q == tsl_pkg::OP_START || op_q == tsl_pkg::OP_STEP)
                              ? na_q : held_a_q;
    end
  end

endmodule

[rtl/tabular_sarsa_lambda_update_core.sv]
// Tabular SARSA(lambda) learner with eligibility traces, Q16.16 values.
// Input channel (in_valid_i/in_ready_o) carries op, reward, next state and
// next action; output channel (out_valid_o/out_ready_i) returns one result
// per transaction: td error and the held state and action.
// Configuration channel (cfg_valid_i/cfg_ready_o) writes discount, trace
// decay, learning rate and trace mode by index; it is always ready, and it
// must be written only while the core is idle; the core does not enforce this.
// A step or end reads the held and next entries and forms the td error and
// gain (ST_RDCUR, ST_RDNXT, ST_MUL, ST_DELTA, ST_GAIN, ST_GAIN2), then makes
// one pass over all 512 table entries at one entry per cycle through a
// single read and a single write port on each table memory, then drains the
// sweep pipeline and loads the result. A start runs a pass that zeroes the
// trace memory. An unknown op loads the result straight away.
// One transaction is worked on at a time; the next is accepted once the
// result sits in the output register, which holds while the receiver stalls.
// After reset the core runs a pass that zeroes both tables and accepts no
// input transaction until it ends.
module tabular_sarsa_lambda_update_core (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              in_valid_i,
  output logic                              in_ready_o,
  input  logic [1:0]                        in_op_i,
  input  logic signed [31:0]                in_reward_i,
  input  logic [tsl_pkg::STATE_W-1:0]       in_next_state_i,
  input  logic [tsl_pkg::ACTION_W-1:0]      in_next_action_i,
  output logic                              out_valid_o,
  input  logic                              out_ready_i,
  output logic signed [31:0]                out_td_error_o,
  output logic [tsl_pkg::STATE_W-1:0]       out_current_state_o,
  output logic [tsl_pkg::ACTION_W-1:0]      out_current_action_o,
  input  logic                              cfg_valid_i,
  output logic                              cfg_ready_o,
  input  logic [1:0]                        cfg_index_i,
  input  logic [16:0]                       cfg_data_i
);

  tsl_pkg::cmd_t cmd;

  assign cfg_ready_o = 1'b1;

  // Controller
  tsl_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .in_op_i     (in_op_i),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .cmd_o       (cmd)
  );

  // Datapath
  tsl_datapath u_datapath (
    .clk_i                (clk_i),
    .rst_ni               (rst_ni),
    .cmd_i                (cmd),
    .in_op_i              (in_op_i),
    .in_reward_i          (in_reward_i),
    .in_next_state_i      (in_next_state_i),
    .in_next_action_i     (in_next_action_i),
    .cfg_we_i             (cfg_valid_i & cfg_ready_o),
    .cfg_index_i          (cfg_index_i),
    .cfg_data_i           (cfg_data_i),
    .out_td_error_o       (out_td_error_o),
    .out_current_state_o  (out_current_state_o),
    .out_current_action_o (out_current_action_o)
  );

endmodule
